### hw/rtl/sat_pkg.sv
// ----------------------------------------------------------------------------
// Switch argument tokenizer package
// Character codes, role codes, the scanner state type and the result word
// shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package sat_pkg;

  // Characters that steer the scanner.
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChEqual = 8'h3D;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChSpace = 8'h20;

  // Role of one character in the result word.
  localparam logic [1:0] RoleNone  = 2'd0;
  localparam logic [1:0] RoleName  = 2'd1;
  localparam logic [1:0] RoleValue = 2'd2;

  // Scanner modes, one-hot.
  typedef enum logic [5:0] {
    ModeIdle   = 6'b000001,
    ModeSwitch = 6'b000010,
    ModeName   = 6'b000100,
    ModeEq     = 6'b001000,
    ModeQuoted = 6'b010000,
    ModeBare   = 6'b100000
  } mode_e;

  // One result word.
  typedef struct packed {
    logic [1:0] role;
    logic [5:0] arg_index;
    logic       name_start;
    logic       value_open;
    logic [6:0] arg_count;
    logic       overflow;
    logic       done_res;
  } res_t;

endpackage

### hw/rtl/sat_in_stage.sv
// ----------------------------------------------------------------------------
// Input stage
// Registers one input word and releases it when the scanner advances.
// ----------------------------------------------------------------------------
module sat_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  input  logic       last_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] ch_o,
  output logic       last_o
);

  logic       valid_q, valid_d;
  logic [7:0] ch_q;
  logic       last_q;
  logic       take;

  // A new word may enter when the stage is empty or its word moves on now.
  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (take) begin
      ch_q   <= ch_i;
      last_q <= last_i;
    end
  end

  assign valid_o = valid_q;
  assign ch_o    = ch_q;
  assign last_o  = last_q;

endmodule

### hw/rtl/sat_scanner.sv
// ----------------------------------------------------------------------------
// Scanner
// Holds the scan mode, the argument count and the overflow flag, and forms
// the result word for the character in the input stage.
// ----------------------------------------------------------------------------
module sat_scanner #(
  parameter int unsigned MAX_ARGS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    ch_i,
  input  logic          last_i,
  output sat_pkg::res_t res_o
);
  import sat_pkg::*;

  localparam logic [6:0] CountCap = (MAX_ARGS < 127) ? 7'(MAX_ARGS) : 7'd127;

  mode_e      mode_q, mode_d, mode_nx;
  logic [6:0] count_q, count_d, count_nx;
  logic       ovf_q, ovf_d, ovf_nx;
  logic       is_sw, is_sp, is_eq, is_qt;
  logic [1:0] role;
  logic       name_start, value_open;

  assign is_sw = (ch_i == ChSlash) || (ch_i == ChDash);
  assign is_sp = (ch_i == ChSpace);
  assign is_eq = (ch_i == ChEqual);
  assign is_qt = (ch_i == ChQuote);

  // Mode transition and tagging of the current character.
  always_comb begin
    mode_nx    = mode_q;
    count_nx   = count_q;
    ovf_nx     = ovf_q;
    role       = RoleNone;
    name_start = 1'b0;
    value_open = 1'b0;
    unique case (mode_q)
      ModeSwitch: begin
        if (is_sp || is_sw) begin
          mode_nx = ModeSwitch;
        end else if (is_eq) begin
          mode_nx = ModeIdle;
        end else begin
          role       = RoleName;
          name_start = 1'b1;
          if (count_q < CountCap) begin
            count_nx = count_q + 7'd1;
          end else begin
            ovf_nx = 1'b1;
          end
          mode_nx = ModeName;
        end
      end
      ModeName: begin
        if (is_sw) begin
          mode_nx = ModeSwitch;
        end else if (is_eq) begin
          mode_nx = ModeEq;
        end else if (is_sp) begin
          mode_nx = ModeIdle;
        end else begin
          role = RoleName;
        end
      end
      ModeEq: begin
        if (is_sp) begin
          mode_nx = ModeEq;
        end else if (is_qt) begin
          value_open = 1'b1;
          mode_nx    = ModeQuoted;
        end else if (is_sw) begin
          value_open = 1'b1;
          mode_nx    = ModeSwitch;
        end else begin
          value_open = 1'b1;
          role       = RoleValue;
          mode_nx    = ModeBare;
        end
      end
      ModeQuoted: begin
        if (is_qt) begin
          mode_nx = ModeIdle;
        end else begin
          role = RoleValue;
        end
      end
      ModeBare: begin
        if (is_sw) begin
          mode_nx = ModeSwitch;
        end else if (is_sp) begin
          mode_nx = ModeIdle;
        end else begin
          role = RoleValue;
        end
      end
      default: begin
        mode_nx = is_sw ? ModeSwitch : ModeIdle;
      end
    endcase
  end

  // The result reflects the count and flag after this character.
  always_comb begin
    res_o.role       = role;
    res_o.arg_index  = (count_nx != 7'd0) ? 6'(count_nx - 7'd1) : 6'd0;
    res_o.name_start = name_start;
    res_o.value_open = value_open;
    res_o.arg_count  = count_nx;
    res_o.overflow   = ovf_nx;
    res_o.done_res   = last_i;
  end

  // The final character of a line returns the scanner to its reset state.
  always_comb begin
    mode_d  = mode_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    if (step_i) begin
      if (last_i) begin
        mode_d  = ModeIdle;
        count_d = 7'd0;
        ovf_d   = 1'b0;
      end else begin
        mode_d  = mode_nx;
        count_d = count_nx;
        ovf_d   = ovf_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      count_q <= 7'd0;
      ovf_q   <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

### hw/rtl/sat_out_stage.sv
// ----------------------------------------------------------------------------
// Output stage
// Result register that holds a word until the receiver takes it.
// ----------------------------------------------------------------------------
module sat_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  sat_pkg::res_t res_i,
  output logic          free_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sat_pkg::res_t res_o
);
  import sat_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // The register can take a word when empty or when its word leaves now.
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

### hw/rtl/switch_argument_tokenizer_core.sv
// ----------------------------------------------------------------------------
// Switch argument tokenizer
// Tags each character of a command line as separator, name or value text.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i / in_ready_o) carries one word per character:
// ch_i and last_i, where last_i marks the final character of a line. The
// output channel (out_valid_o / out_ready_i) returns one word per character
// with its role, the argument index and count, the name and value markers,
// the overflow flag and done_res_o, a copy of last_i.
// A word accepted at the input is registered in the input register, scanned by
// one level of mode logic and loaded into the result register once that
// register is free. One word per cycle is taken and delivered in steady state
// while the receiver does not stall.
// The input and output registers are separate, so a new word is taken while
// a result waits; a stalled receiver holds the output and, once the input
// register is also full, drops in_ready_o.
// Reset clears both registers, the scan mode, the count and the overflow
// flag. After a word with last_i set the mode, count and flag return to the same values.
// ----------------------------------------------------------------------------
module switch_argument_tokenizer_core #(
  parameter int unsigned MAX_ARGS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] role_o,
  output logic [5:0] arg_index_o,
  output logic       name_start_o,
  output logic       value_open_o,
  output logic [6:0] arg_count_o,
  output logic       overflow_o,
  output logic       done_res_o
);
  import sat_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_ch;
  logic       s1_last;
  logic       out_free;
  logic       advance;
  res_t       scan_res;
  res_t       out_res;

  // A word moves on when it is present and the result register can take it.
  assign advance = s1_valid && out_free;

  sat_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .ch_i       (ch_i),
    .last_i     (last_i),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .ch_o       (s1_ch),
    .last_o     (s1_last)
  );

  sat_scanner #(
    .MAX_ARGS (MAX_ARGS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .ch_i   (s1_ch),
    .last_i (s1_last),
    .res_o  (scan_res)
  );

  sat_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_i       (scan_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign role_o       = out_res.role;
  assign arg_index_o  = out_res.arg_index;
  assign name_start_o = out_res.name_start;
  assign value_open_o = out_res.value_open;
  assign arg_count_o  = out_res.arg_count;
  assign overflow_o   = out_res.overflow;
  assign done_res_o   = out_res.done_res;

endmodule

### hw/rtl/sat_checker.sv
// ----------------------------------------------------------------------------
// Tokenizer port checker
// Watches the top level's ports for consistency of the result words.
// ----------------------------------------------------------------------------
module sat_checker #(
  parameter int unsigned MAX_ARGS = 64
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] ch_i,
  input logic       last_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] role_o,
  input logic [5:0] arg_index_o,
  input logic       name_start_o,
  input logic       value_open_o,
  input logic [6:0] arg_count_o,
  input logic       overflow_o,
  input logic       done_res_o
);
  import sat_pkg::*;

  localparam logic [6:0] CountCap = (MAX_ARGS < 127) ? 7'(MAX_ARGS) : 7'd127;

  // A waiting input word keeps its payload until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(ch_i) && $stable(last_i))
    else $error("input word changed while waiting");

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(role_o)
      && $stable(arg_count_o) && $stable(done_res_o))
    else $error("result word changed while stalled");

  // A character that starts a name is itself a name character and opens no value.
  a_name_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && name_start_o |-> role_o == RoleName && arg_count_o != 7'd0
      && !value_open_o)
    else $error("name start without a name role or count");

  // Overflow is only possible with the count saturated.
  a_ovf_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> arg_count_o == CountCap)
    else $error("overflow below the argument cap");

  // The index trails the count by one.
  a_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && arg_count_o != 7'd0 |-> arg_index_o == 6'(arg_count_o - 7'd1))
    else $error("argument index does not follow the count");

endmodule

bind switch_argument_tokenizer_core sat_checker #(.MAX_ARGS(MAX_ARGS)) u_sat_checker (.*);

### verif/switch_argument_tokenizer_core_test.sv
// ----------------------------------------------------------------------------
// Switch argument tokenizer testbench
// Streams command lines through the tokenizer one character word at a time and
// checks every result word against a cycle-free predictor of the scanner or a
// typed expectation. A short table of hand-picked lines comes first, then random
// lines built from switches, names and quoted, bare, empty or absent values, with
// noise mixed in and two lines long enough to overflow the argument count. Both
// channels stall in random bursts, except in the last part of the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module switch_argument_tokenizer_core_test;
  import sat_pkg::*;

  localparam int unsigned MaxArgs    = 64;
  localparam int unsigned CountCap   = (MaxArgs < 127) ? MaxArgs : 127;
  localparam int          StallLimit = 2000;
  localparam int          RandWords  = 800;
  localparam int          DirLen     = 31;
  localparam res_t        ResZero    = '0;

  // One row of the directed table; want is used only where typed is set.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    res_t       want;
  } row_t;

  localparam row_t DirRows [DirLen] = '{
    // After reset: a switch with a skipped space, then a one-letter name.
    '{ChSlash, 1'b0, 1'b1, ResZero},
    '{ChSpace, 1'b0, 1'b1, ResZero},
    '{"a",     1'b0, 1'b1, '{RoleName, 6'd0, 1'b1, 1'b0, 7'd1, 1'b0, 1'b0}},
    // Quoted value after a space, holding a single letter.
    '{ChEqual, 1'b0, 1'b0, ResZero},
    '{ChSpace, 1'b0, 1'b0, ResZero},
    '{ChQuote, 1'b0, 1'b0, ResZero},
    '{"v",     1'b0, 1'b0, ResZero},
    '{ChQuote, 1'b0, 1'b0, ResZero},
    // A switch followed directly by an equals sign begins nothing.
    '{ChDash,  1'b0, 1'b0, ResZero},
    '{ChEqual, 1'b0, 1'b0, ResZero},
    // Zero character as a name, ended by a space; the later equals is ignored.
    '{ChDash,  1'b0, 1'b0, ResZero},
    '{8'h00,   1'b0, 1'b0, ResZero},
    '{ChSpace, 1'b0, 1'b0, ResZero},
    '{ChEqual, 1'b0, 1'b0, ResZero},
    // Empty value: the next switch opens the value and a new switch.
    '{ChSlash, 1'b0, 1'b0, ResZero},
    '{"b",     1'b0, 1'b0, ResZero},
    '{ChEqual, 1'b0, 1'b0, ResZero},
    '{ChSpace, 1'b0, 1'b0, ResZero},
    '{ChDash,  1'b0, 1'b0, ResZero},
    // Absent value: only spaces follow the equals sign up to the end.
    '{"c",     1'b0, 1'b0, ResZero},
    '{ChEqual, 1'b0, 1'b0, ResZero},
    '{ChSpace, 1'b1, 1'b1, '{RoleNone, 6'd3, 1'b0, 1'b0, 7'd4, 1'b0, 1'b1}},
    // New line: state is back to reset; bare value of the top character.
    '{ChDash,  1'b0, 1'b1, ResZero},
    '{8'h01,   1'b0, 1'b1, '{RoleName, 6'd0, 1'b1, 1'b0, 7'd1, 1'b0, 1'b0}},
    '{ChEqual, 1'b0, 1'b0, ResZero},
    '{8'hFF,   1'b0, 1'b0, ResZero},
    // Unclosed quote running to the end of the line.
    '{ChSlash, 1'b0, 1'b0, ResZero},
    '{"q",     1'b0, 1'b0, ResZero},
    '{ChEqual, 1'b0, 1'b0, ResZero},
    '{ChQuote, 1'b0, 1'b0, ResZero},
    '{"z",     1'b1, 1'b0, ResZero}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid;
  logic       in_ready_o;
  logic [7:0] ch;
  logic       last;
  logic       out_valid_o;
  logic       out_ready;
  logic [1:0] role_o;
  logic [5:0] arg_index_o;
  logic       name_start_o;
  logic       value_open_o;
  logic [6:0] arg_count_o;
  logic       overflow_o;
  logic       done_res_o;

  // Predictor state: the scanner mode, names begun and the rejection flag.
  mode_e      scan_mode;
  logic [6:0] names_begun;
  logic       rejected;

  res_t       pending_tags [$];
  logic [7:0] line_chars [$];
  bit         calm;
  bit         gappy;
  int         words_in;
  int         lines_sent;
  int         tags_checked;
  int         rejected_lines;
  int         errors;
  int         quiet_cycles;

  switch_argument_tokenizer_core #(
    .MAX_ARGS(MaxArgs)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .ch_i        (ch),
    .last_i      (last),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .role_o      (role_o),
    .arg_index_o (arg_index_o),
    .name_start_o(name_start_o),
    .value_open_o(value_open_o),
    .arg_count_o (arg_count_o),
    .overflow_o  (overflow_o),
    .done_res_o  (done_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Tags one character and moves the predicted scanner on.
  function automatic res_t tokenize_char(input logic [7:0] c, input logic lst);
    res_t  r;
    mode_e nxt;
    logic  sw;
    r   = '0;
    nxt = scan_mode;
    sw  = (c == ChSlash) || (c == ChDash);
    case (scan_mode)
      ModeSwitch: begin
        if (c == ChSpace || sw) begin
          nxt = ModeSwitch;
        end else if (c == ChEqual) begin
          nxt = ModeIdle;
        end else begin
          r.role       = RoleName;
          r.name_start = 1'b1;
          if (names_begun < CountCap) names_begun = names_begun + 7'd1;
          else rejected = 1'b1;
          nxt = ModeName;
        end
      end
      ModeName: begin
        if (sw) nxt = ModeSwitch;
        else if (c == ChEqual) nxt = ModeEq;
        else if (c == ChSpace) nxt = ModeIdle;
        else r.role = RoleName;
      end
      ModeEq: begin
        if (c == ChSpace) begin
          nxt = ModeEq;
        end else if (c == ChQuote) begin
          r.value_open = 1'b1;
          nxt = ModeQuoted;
        end else if (sw) begin
          r.value_open = 1'b1;
          nxt = ModeSwitch;
        end else begin
          r.value_open = 1'b1;
          r.role       = RoleValue;
          nxt = ModeBare;
        end
      end
      ModeQuoted: begin
        if (c == ChQuote) nxt = ModeIdle;
        else r.role = RoleValue;
      end
      ModeBare: begin
        if (sw) nxt = ModeSwitch;
        else if (c == ChSpace) nxt = ModeIdle;
        else r.role = RoleValue;
      end
      default: nxt = sw ? ModeSwitch : ModeIdle;
    endcase
    r.arg_index = (names_begun != 0) ? 6'(names_begun - 7'd1) : 6'd0;
    r.arg_count = names_begun;
    r.overflow  = rejected;
    r.done_res  = lst;
    // The end of a line puts the scanner back to its reset state.
    if (lst) begin
      scan_mode   = ModeIdle;
      names_begun = '0;
      rejected    = 1'b0;
    end else begin
      scan_mode = nxt;
    end
    return r;
  endfunction

  // Random characters of the three text classes.
  function automatic logic [7:0] name_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == ChSlash || c == ChDash || c == ChEqual || c == ChSpace);
    return c;
  endfunction

  function automatic logic [7:0] bare_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == ChSlash || c == ChDash || c == ChSpace);
    return c;
  endfunction

  function automatic logic [7:0] quoted_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == ChQuote);
    return c;
  endfunction

  // Offers one word and waits for it to be taken. An accepted word is tagged
  // by the predictor, or by the typed expectation where one is given.
  task automatic send_word(input logic [7:0] c, input logic lst, input logic typed,
                           input res_t want);
    res_t tag;
    if (!calm && gappy && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    ch       <= c;
    last     <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    tag = tokenize_char(c, lst);
    pending_tags.push_back(typed ? want : tag);
    words_in++;
  endtask

  // Holds the sender off until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_tags.size() != 0) @(posedge clk_i);
  endtask

  // Builds one command line. Brief lines hold one-letter switches only, to
  // push the argument count past its cap quickly.
  task automatic build_line(input int n_args, input bit noisy, input bit brief);
    int n_name;
    line_chars.delete();
    for (int a = 0; a < n_args; a++) begin
      if (noisy && $urandom_range(0, 5) == 0) line_chars.push_back(8'($urandom_range(1, 255)));
      line_chars.push_back($urandom_range(0, 1) ? ChSlash : ChDash);
      if (brief) begin
        line_chars.push_back(name_char());
        continue;
      end
      if ($urandom_range(0, 3) == 0) line_chars.push_back(ChSpace);
      if ($urandom_range(0, 11) == 0) begin
        line_chars.push_back(ChEqual);
        continue;
      end
      n_name = $urandom_range(1, 4);
      repeat (n_name) line_chars.push_back(name_char());
      case ($urandom_range(0, 5))
        0: ;
        1: begin
          line_chars.push_back(ChSpace);
          if ($urandom_range(0, 1) == 1) line_chars.push_back(ChEqual);
        end
        2: begin
          line_chars.push_back(ChEqual);
          repeat ($urandom_range(0, 2)) line_chars.push_back(ChSpace);
          line_chars.push_back(ChQuote);
          repeat ($urandom_range(0, 4)) line_chars.push_back(quoted_char());
          if (a != n_args - 1 || $urandom_range(0, 1) == 1) line_chars.push_back(ChQuote);
        end
        3: begin
          line_chars.push_back(ChEqual);
          repeat ($urandom_range(0, 2)) line_chars.push_back(ChSpace);
          repeat ($urandom_range(1, 4)) line_chars.push_back(bare_char());
        end
        // Empty value if a switch follows, absent value at the end.
        default: begin
          line_chars.push_back(ChEqual);
          repeat ($urandom_range(0, 2)) line_chars.push_back(ChSpace);
        end
      endcase
      if ($urandom_range(0, 3) == 0) line_chars.push_back(ChSpace);
    end
    if (noisy || line_chars.size() == 0) line_chars.push_back(8'($urandom_range(1, 255)));
  endtask

  // Main stimulus: directed table, then random lines, then the wind-down.
  initial begin : stimulus
    int line_no;
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    ch          = '0;
    last        = 1'b0;
    calm        = 1'b0;
    gappy       = 1'b1;
    scan_mode   = ModeIdle;
    names_begun = '0;
    rejected    = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[i]) send_word(DirRows[i].ch, DirRows[i].last, DirRows[i].typed,
                                   DirRows[i].want);
    lines_sent = 2;
    drain();

    line_no = 0;
    while (words_in < DirLen + RandWords) begin
      gappy = ($urandom_range(0, 2) != 0);
      if (line_no == 4 || line_no == 30) begin
        if (line_no == 30) drain();
        build_line($urandom_range(MaxArgs + 1, MaxArgs + 8), 1'b0, 1'b1);
      end else begin
        build_line($urandom_range(0, 6), $urandom_range(0, 3) == 0, 1'b0);
      end
      foreach (line_chars[i]) send_word(line_chars[i], i == line_chars.size() - 1, 1'b0,
                                        ResZero);
      lines_sent++;
      line_no++;
      if (words_in >= DirLen + RandWords - 100) calm = 1'b1;
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_tags.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d characters in %0d lines; %0d result words checked.",
             words_in, lines_sent, tags_checked);
    $display("%0d lines ended over the argument limit of %0d.", rejected_lines, MaxArgs);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Receiver: random stall bursts and quiet stretches, none near the end.
  initial begin : receiver
    out_ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (!calm) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk_i);
            out_ready <= 1'b1;
          end
          2: repeat ($urandom_range(20, 60)) @(posedge clk_i);
          default: ;
        endcase
      end
    end
  end

  task automatic report_field(input string fname, input logic [7:0] want,
                              input logic [7:0] got);
    errors++;
    if (errors <= 20) $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname,
                               want, got);
  endtask

  // Compares each result word with the oldest expectation.
  always @(posedge clk_i) begin : check_tags
    res_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_tags.size() == 0) begin
        errors++;
        if (errors <= 20) $display("%0t: result word with nothing expected, role %0d", $time,
                                   role_o);
      end else begin
        want = pending_tags.pop_front();
        if (role_o !== want.role) report_field("role", 8'(want.role), 8'(role_o));
        if (arg_index_o !== want.arg_index) report_field("arg_index", 8'(want.arg_index),
                                                         8'(arg_index_o));
        if (name_start_o !== want.name_start) report_field("name_start",
                                                           8'(want.name_start),
                                                           8'(name_start_o));
        if (value_open_o !== want.value_open) report_field("value_open",
                                                           8'(want.value_open),
                                                           8'(value_open_o));
        if (arg_count_o !== want.arg_count) report_field("arg_count", 8'(want.arg_count),
                                                         8'(arg_count_o));
        if (overflow_o !== want.overflow) report_field("overflow", 8'(want.overflow),
                                                       8'(overflow_o));
        if (done_res_o !== want.done_res) report_field("done_res", 8'(want.done_res),
                                                       8'(done_res_o));
        tags_checked++;
        if (want.done_res && want.overflow) rejected_lines++;
      end
    end
  end

  // Watchdog: too long without a word moving on either channel ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == StallLimit) begin
      $display("%0t: no word moved for %0d cycles, %0d results outstanding", $time,
               StallLimit, pending_tags.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
